// ===== hdl/mjts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mjts_pkg: shared types and constants of the MiniJava token scanner
// Token codes, the token record that moves from the scanner to the output
// stage, and sizing constants.
// ----------------------------------------------------------------------------
package mjts_pkg;

   localparam int MAX_WORD    = 24;
   localparam int OFFSET_BITS = 24;
   localparam int WLEN_W      = $clog2(MAX_WORD + 2);
   localparam int IDX_W       = $clog2(MAX_WORD);
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [5:0] TK_EOF = 6'd0,  TK_BAD = 6'd1,  TK_COLON = 6'd2,
      TK_SEMI = 6'd3, TK_DOT = 6'd4, TK_COMMA = 6'd5, TK_EQSIGN = 6'd6,
      TK_EQUALS = 6'd7, TK_LPAREN = 6'd8, TK_RPAREN = 6'd9, TK_LBRACKET = 6'd10,
      TK_RBRACKET = 6'd11, TK_LBRACE = 6'd12, TK_RBRACE = 6'd13, TK_AND = 6'd14,
      TK_OR = 6'd15, TK_LESSTHAN = 6'd16, TK_PLUS = 6'd17, TK_MINUS = 6'd18,
      TK_TIMES = 6'd19, TK_DIV = 6'd20, TK_CLASS = 6'd21, TK_PUBLIC = 6'd22,
      TK_STATIC = 6'd23, TK_VOID = 6'd24, TK_STRING = 6'd25, TK_EXTENDS = 6'd26,
      TK_INT = 6'd27, TK_BOOLEAN = 6'd28, TK_WHILE = 6'd29, TK_IF = 6'd30,
      TK_ELSE = 6'd31, TK_MAIN = 6'd32, TK_LENGTH = 6'd33, TK_RETURN = 6'd34,
      TK_TRUE = 6'd35, TK_FALSE = 6'd36, TK_THIS = 6'd37, TK_NEW = 6'd38,
      TK_PRINTLN = 6'd39, TK_SIDEF = 6'd40, TK_ID = 6'd41, TK_STRINGLIT = 6'd42,
      TK_INTLIT = 6'd43, TK_BANG = 6'd44;

   localparam logic [30:0] INT_MAXV = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [5:0]  kind;
      logic [30:0] ival;
      logic        ovf;
      logic [15:0] row;
      logic [15:0] col;
      logic [23:0] off;
      logic [23:0] len;
      logic        last;
   } tok_type;

   typedef struct packed {
      logic [1:0] cnt;
      tok_type    t0;
      tok_type    t1;
   } q_push_type;

   // Fits an offset-wide value into the 24-bit text fields.
   function automatic logic [23:0] to_text24(input logic [OFFSET_BITS-1:0] v);
      logic [63:0] t;
      t = 64'(v);
      return t[23:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/mjts_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mjts_front: character scanner
// Takes one byte per accepted word, tracks position and scan mode, and hands
// up to two finished tokens per word to the token queue.
// ----------------------------------------------------------------------------
module mjts_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_end,
   input  wire logic                 q_space,
   output mjts_pkg::q_push_type      push
);

   localparam logic [3:0] MODE_IDLE = 4'd0, MODE_WORD = 4'd1, MODE_DOT1 = 4'd2,
      MODE_DOT2 = 4'd3, MODE_NUM = 4'd4, MODE_STR = 4'd5, MODE_AMP = 4'd6,
      MODE_BAR = 4'd7, MODE_EQ = 4'd8, MODE_SLASH = 4'd9, MODE_LINE = 4'd10,
      MODE_BLOCK = 4'd11, MODE_BSTAR = 4'd12;

   localparam int OB = mjts_pkg::OFFSET_BITS;
   localparam int WW = mjts_pkg::WLEN_W;

   logic [3:0]    mode_ff, mode_in;
   logic [7:0]    buf_ff [mjts_pkg::MAX_WORD];
   logic [WW-1:0] wlen_ff, wlen_in;
   logic [30:0]   acc_ff, acc_in;
   logic          sat_ff, sat_in;
   logic [15:0]   srow_ff, srow_in, scol_ff, scol_in, crow_ff, crow_in, ccol_ff, ccol_in;
   logic [OB-1:0] soff_ff, soff_in, coff_ff, coff_in;

   logic          accept, used, app, start_word, a_v, b_v;
   logic          is_al, is_dg, is_sp;
   logic [WW-1:0] app_base;
   logic          app_wr;
   logic [34:0]   acc_next;
   mjts_pkg::tok_type tok_a, tok_b, tok_fw;
   logic          kw_hit;
   logic [5:0]    kw_code;

   function automatic logic word_is(input logic [WW-1:0] wl,
                                    input logic [8*18-1:0] s, input int n);
      logic hit;
      int   j;
      hit = (wl == WW'(n));
      for (int i = 0; i < 18; i++) begin
         j = (i < n) ? (n - 1 - i) : 0;
         if (i < n && buf_ff[i] != s[8*j +: 8]) hit = 1'b0;
      end
      return hit;
   endfunction

   function automatic logic [5:0] sym_code(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h3A: k = mjts_pkg::TK_COLON;
         8'h3B: k = mjts_pkg::TK_SEMI;
         8'h2E: k = mjts_pkg::TK_DOT;
         8'h2C: k = mjts_pkg::TK_COMMA;
         8'h28: k = mjts_pkg::TK_LPAREN;
         8'h29: k = mjts_pkg::TK_RPAREN;
         8'h5B: k = mjts_pkg::TK_LBRACKET;
         8'h5D: k = mjts_pkg::TK_RBRACKET;
         8'h7B: k = mjts_pkg::TK_LBRACE;
         8'h7D: k = mjts_pkg::TK_RBRACE;
         8'h3C: k = mjts_pkg::TK_LESSTHAN;
         8'h2B: k = mjts_pkg::TK_PLUS;
         8'h2D: k = mjts_pkg::TK_MINUS;
         8'h2A: k = mjts_pkg::TK_TIMES;
         8'h21: k = mjts_pkg::TK_BANG;
         default: k = mjts_pkg::TK_BAD;
      endcase
      return k;
   endfunction

   assign in_ready = q_space;
   assign accept   = in_valid && in_ready;

   assign is_al = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
   assign is_dg = in_byte >= "0" && in_byte <= "9";
   assign is_sp = in_byte == " " || (in_byte >= 8'd9 && in_byte <= 8'd13);

   // Keyword compare runs on all table entries at once.
   always_comb begin
      kw_hit  = 1'b1;
      kw_code = mjts_pkg::TK_ID;
      if      (word_is(wlen_ff, "eof", 3))     kw_code = mjts_pkg::TK_EOF;
      else if (word_is(wlen_ff, "bad", 3))     kw_code = mjts_pkg::TK_BAD;
      else if (word_is(wlen_ff, "class", 5))   kw_code = mjts_pkg::TK_CLASS;
      else if (word_is(wlen_ff, "public", 6))  kw_code = mjts_pkg::TK_PUBLIC;
      else if (word_is(wlen_ff, "static", 6))  kw_code = mjts_pkg::TK_STATIC;
      else if (word_is(wlen_ff, "void", 4))    kw_code = mjts_pkg::TK_VOID;
      else if (word_is(wlen_ff, "String", 6))  kw_code = mjts_pkg::TK_STRING;
      else if (word_is(wlen_ff, "extends", 7)) kw_code = mjts_pkg::TK_EXTENDS;
      else if (word_is(wlen_ff, "int", 3))     kw_code = mjts_pkg::TK_INT;
      else if (word_is(wlen_ff, "boolean", 7)) kw_code = mjts_pkg::TK_BOOLEAN;
      else if (word_is(wlen_ff, "while", 5))   kw_code = mjts_pkg::TK_WHILE;
      else if (word_is(wlen_ff, "if", 2))      kw_code = mjts_pkg::TK_IF;
      else if (word_is(wlen_ff, "else", 4))    kw_code = mjts_pkg::TK_ELSE;
      else if (word_is(wlen_ff, "main", 4))    kw_code = mjts_pkg::TK_MAIN;
      else if (word_is(wlen_ff, "length", 6))  kw_code = mjts_pkg::TK_LENGTH;
      else if (word_is(wlen_ff, "return", 6))  kw_code = mjts_pkg::TK_RETURN;
      else if (word_is(wlen_ff, "true", 4))    kw_code = mjts_pkg::TK_TRUE;
      else if (word_is(wlen_ff, "false", 5))   kw_code = mjts_pkg::TK_FALSE;
      else if (word_is(wlen_ff, "this", 4))    kw_code = mjts_pkg::TK_THIS;
      else if (word_is(wlen_ff, "new", 3))     kw_code = mjts_pkg::TK_NEW;
      else if (word_is(wlen_ff, "sidef", 5))   kw_code = mjts_pkg::TK_SIDEF;
      else kw_hit = 1'b0;
   end

   // Token for a word that ends here.
   always_comb begin
      tok_fw     = '0;
      tok_fw.row = srow_ff;
      tok_fw.col = scol_ff;
      if (mode_ff == MODE_WORD && kw_hit) begin
         tok_fw.kind = kw_code;
      end else if (mode_ff == MODE_DOT2 && word_is(wlen_ff, "System.out.println", 18)) begin
         tok_fw.kind = mjts_pkg::TK_PRINTLN;
      end else begin
         tok_fw.kind = mjts_pkg::TK_ID;
         tok_fw.off  = mjts_pkg::to_text24(soff_ff);
         tok_fw.len  = mjts_pkg::to_text24(coff_ff - soff_ff);
      end
   end

   assign acc_next = (35'(acc_ff) << 3) + (35'(acc_ff) << 1) + 35'(in_byte - "0");

   always_comb begin
      mode_in = mode_ff;  wlen_in = wlen_ff;  acc_in = acc_ff;  sat_in = sat_ff;
      srow_in = srow_ff;  scol_in = scol_ff;  soff_in = soff_ff;
      crow_in = crow_ff;  ccol_in = ccol_ff;  coff_in = coff_ff;
      used = 1'b0;  app = 1'b0;  start_word = 1'b0;
      a_v = 1'b0;  b_v = 1'b0;
      tok_a = '0;  tok_a.row = srow_ff;  tok_a.col = scol_ff;
      tok_b = '0;

      unique case (mode_ff)
         MODE_WORD: begin
            if (!in_end && (is_al || is_dg || in_byte == "_")) begin
               app = 1'b1;  used = 1'b1;
            end else if (!in_end && in_byte == "." && word_is(wlen_ff, "System", 6)) begin
               app = 1'b1;  used = 1'b1;  mode_in = MODE_DOT1;
            end else begin
               a_v = 1'b1;  tok_a = tok_fw;  mode_in = MODE_IDLE;
            end
         end
         MODE_DOT1: begin
            if (!in_end && is_al) begin
               app = 1'b1;  used = 1'b1;
            end else if (!in_end && in_byte == "." && word_is(wlen_ff, "System.out", 10)) begin
               app = 1'b1;  used = 1'b1;  mode_in = MODE_DOT2;
            end else begin
               a_v = 1'b1;  tok_a = tok_fw;  mode_in = MODE_IDLE;
            end
         end
         MODE_DOT2: begin
            if (!in_end && (is_al || is_dg)) begin
               app = 1'b1;  used = 1'b1;
            end else begin
               a_v = 1'b1;  tok_a = tok_fw;  mode_in = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (!in_end && is_dg) begin
               used = 1'b1;
               if (acc_next > 35'(mjts_pkg::INT_MAXV)) begin
                  acc_in = mjts_pkg::INT_MAXV;  sat_in = 1'b1;
               end else begin
                  acc_in = acc_next[30:0];
               end
            end else begin
               a_v = 1'b1;  tok_a.kind = mjts_pkg::TK_INTLIT;
               tok_a.ival = acc_ff;  tok_a.ovf = sat_ff;  mode_in = MODE_IDLE;
            end
         end
         MODE_STR: begin
            if (in_end) begin
               a_v = 1'b1;  tok_a.kind = mjts_pkg::TK_BAD;  mode_in = MODE_IDLE;
            end else begin
               used = 1'b1;
               if (in_byte == 8'h22) begin
                  a_v = 1'b1;  tok_a.kind = mjts_pkg::TK_STRINGLIT;
                  tok_a.off = mjts_pkg::to_text24(soff_ff + 1'b1);
                  tok_a.len = mjts_pkg::to_text24(coff_ff - soff_ff - 1'b1);
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_AMP, MODE_BAR: begin
            if (!in_end && in_byte == ((mode_ff == MODE_AMP) ? "&" : "|")) begin
               a_v = 1'b1;  used = 1'b1;
               tok_a.kind = (mode_ff == MODE_AMP) ? mjts_pkg::TK_AND : mjts_pkg::TK_OR;
            end
            mode_in = MODE_IDLE;
         end
         MODE_EQ: begin
            a_v = 1'b1;
            if (!in_end && in_byte == "=") begin
               tok_a.kind = mjts_pkg::TK_EQUALS;  used = 1'b1;
            end else begin
               tok_a.kind = mjts_pkg::TK_EQSIGN;
            end
            mode_in = MODE_IDLE;
         end
         MODE_SLASH: begin
            if (!in_end && in_byte == "/") begin
               mode_in = MODE_LINE;  used = 1'b1;
            end else if (!in_end && in_byte == "*") begin
               mode_in = MODE_BLOCK;  used = 1'b1;
            end else begin
               a_v = 1'b1;  tok_a.kind = mjts_pkg::TK_DIV;  mode_in = MODE_IDLE;
            end
         end
         MODE_LINE: begin
            if (in_end || in_byte == 8'h0A) mode_in = MODE_IDLE;
            used = !in_end;
         end
         MODE_BLOCK: begin
            if (in_end) begin
               mode_in = MODE_IDLE;
            end else begin
               if (in_byte == "*") mode_in = MODE_BSTAR;
               used = 1'b1;
            end
         end
         MODE_BSTAR: begin
            if (in_end || in_byte == "/") mode_in = MODE_IDLE;
            else if (in_byte != "*") mode_in = MODE_BLOCK;
            used = !in_end;
         end
         default: mode_in = MODE_IDLE;
      endcase

      if (in_end) begin
         b_v = 1'b1;  tok_b.kind = mjts_pkg::TK_EOF;
         tok_b.row = crow_ff;  tok_b.col = ccol_ff;
         mode_in = MODE_IDLE;
         crow_in = 16'd1;  ccol_in = 16'd1;  coff_in = '0;
      end else begin
         if (!used) begin
            srow_in = crow_ff;  scol_in = ccol_ff;  soff_in = coff_ff;
            if (is_al) begin
               start_word = 1'b1;  app = 1'b1;  mode_in = MODE_WORD;
            end else if (is_dg) begin
               acc_in = 31'(in_byte - "0");  sat_in = 1'b0;  mode_in = MODE_NUM;
            end else if (in_byte == 8'h22) mode_in = MODE_STR;
            else if (in_byte == "&") mode_in = MODE_AMP;
            else if (in_byte == "|") mode_in = MODE_BAR;
            else if (in_byte == "=") mode_in = MODE_EQ;
            else if (in_byte == "/") mode_in = MODE_SLASH;
            else if (!is_sp) begin
               b_v = 1'b1;  tok_b.kind = sym_code(in_byte);
               tok_b.row = crow_ff;  tok_b.col = ccol_ff;
            end
         end
         coff_in = coff_ff + 1'b1;
         if (in_byte == 8'h0A) begin
            if (crow_ff != 16'hFFFF) crow_in = crow_ff + 16'd1;
            ccol_in = 16'd1;
         end else if (ccol_ff != 16'hFFFF) begin
            ccol_in = ccol_ff + 16'd1;
         end
      end

      // Words longer than the buffer keep a length of one past its depth.
      app_base = start_word ? '0 : wlen_ff;
      app_wr   = app && (app_base < WW'(mjts_pkg::MAX_WORD));
      if (app) wlen_in = app_wr ? app_base + 1'b1 : WW'(mjts_pkg::MAX_WORD + 1);
   end

   always_comb begin
      push = '0;
      if (accept) begin
         push.cnt = {1'b0, a_v} + {1'b0, b_v};
         if (a_v) begin
            push.t0 = tok_a;  push.t0.last = !b_v;
            push.t1 = tok_b;  push.t1.last = 1'b1;
         end else begin
            push.t0 = tok_b;  push.t0.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;  wlen_ff <= '0;  acc_ff <= '0;  sat_ff <= 1'b0;
         srow_ff <= 16'd1;  scol_ff <= 16'd1;  soff_ff <= '0;
         crow_ff <= 16'd1;  ccol_ff <= 16'd1;  coff_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;  wlen_ff <= wlen_in;  acc_ff <= acc_in;  sat_ff <= sat_in;
         srow_ff <= srow_in;  scol_ff <= scol_in;  soff_ff <= soff_in;
         crow_ff <= crow_in;  ccol_ff <= ccol_in;  coff_ff <= coff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && app_wr) buf_ff[app_base[mjts_pkg::IDX_W-1:0]] <= in_byte;
   end

endmodule
`default_nettype wire

// ===== hdl/mjts_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mjts_queue: token queue
// Takes up to two tokens per cycle from the scanner, which pushes only while two
// entries are free, and releases one per cycle while the output stage takes it.
// ----------------------------------------------------------------------------
module mjts_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  mjts_pkg::q_push_type      push,
   output logic                      space,
   output logic                      q_valid,
   output mjts_pkg::tok_type         q_data,
   input  wire logic                 q_pop
);

   localparam int PW = mjts_pkg::QPTR_W;
   localparam int CW = mjts_pkg::QCNT_W;

   mjts_pkg::tok_type mem_ff [mjts_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign space   = cnt_ff <= CW'(mjts_pkg::QDEPTH - 2);
   assign q_valid = cnt_ff != '0;
   assign q_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + PW'(push.cnt);
         rd_ff  <= rd_ff + PW'(q_pop);
         cnt_ff <= cnt_ff + CW'(push.cnt) - CW'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) mem_ff[wr_ff] <= push.t0;
      if (push.cnt == 2'd2) mem_ff[wr_ff + 1'b1] <= push.t1;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(mjts_pkg::QDEPTH)) else $error("token queue overfilled");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> cnt_ff != '0) else $error("pop from empty token queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.cnt != 2'd0 |-> space) else $error("push without room");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (push.cnt == 2'd0 && !q_pop) |=> cnt_ff == $past(cnt_ff))
      else $error("queue count moved without traffic");

endmodule
`default_nettype wire

// ===== hdl/mjts_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mjts_back: output stage
// Holds one token on the result channel and refills from the queue as the
// consumer takes words.
// ----------------------------------------------------------------------------
module mjts_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  mjts_pkg::tok_type    q_data,
   output logic                 q_pop,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output mjts_pkg::tok_type    out_tok
);

   logic              valid_ff;
   mjts_pkg::tok_type tok_ff;

   assign q_pop     = q_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (q_pop) valid_ff <= 1'b1;
      else if (out_ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) tok_ff <= q_data;
   end

endmodule
`default_nettype wire

// ===== hdl/minijava_token_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// minijava_token_scanner: streaming MiniJava lexer
// One source byte per input word, tokens out as they are resolved.
// ----------------------------------------------------------------------------
// Each input word carries one source byte, or an end-of-file flag in tuser.
// The scanner takes one word per cycle and emits zero, one or two tokens for
// it: the pending token that this byte closes, then a one-character token or
// EOF; tlast marks the final token caused by a word. The result channel moves
// one token per cycle while the consumer is ready; a four-entry token queue
// between the scanner and the output register absorbs words that yield two
// tokens, and the input stalls only while fewer than two queue entries are
// free. An accepted byte's first token is written into the queue, then into
// the output register, before it shows on the result port. Keywords are
// matched against the first 24 bytes of a word, all in parallel. Integer
// literals saturate at 2147483647 with the overflow flag set; identifiers and
// strings are given as a byte offset and a length rather than text.
module minijava_token_scanner (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] char_byte
   input  wire logic [0:0]    req_tuser,   // [0] end_marker
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [111:0]       rsp_tdata,   // [30:0] int_value, [31] int_overflow,
                                           // [47:32] token_row, [63:48] token_column,
                                           // [87:64] text_offset, [111:88] text_length
   output logic [5:0]         rsp_tuser,   // [5:0] token_kind
   output logic               rsp_tlast    // last_of_run
);

   mjts_pkg::q_push_type push;
   mjts_pkg::tok_type    q_data, out_tok;
   logic                 space, q_valid, q_pop;

   mjts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tuser[0]),
      .q_space  (space),
      .push     (push)
   );

   mjts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .space   (space),
      .q_valid (q_valid),
      .q_data  (q_data),
      .q_pop   (q_pop)
   );

   mjts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (out_tok)
   );

   assign rsp_tdata = {out_tok.len, out_tok.off, out_tok.col, out_tok.row,
                       out_tok.ovf, out_tok.ival};
   assign rsp_tuser = out_tok.kind;
   assign rsp_tlast = out_tok.last;

endmodule
`default_nettype wire
